// File: hw/rtl/sp1h_pkg.sv
// Package for the shortest-path-with-one-halved-edge block: widths, defaults and row types.
`timescale 1ns / 1ps

package sp1h_pkg;

    // Field widths fixed by the interface
    localparam int NODE_W    = 10;
    localparam int WEIGHT_W  = 32;
    localparam int COST_W    = 48;
    localparam int CFG_W     = 11;
    localparam int EDGE_W    = 2 * NODE_W + WEIGHT_W;

    // Parameter defaults
    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;

    // Reset value of the node count register
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(2);

    // One distance: an infinity mark and a cost
    typedef struct packed {
        logic              inf;
        logic [COST_W-1:0] cost;
    } dist_t;

    // One distance row: both layers of one node
    typedef struct packed {
        dist_t l1;
        dist_t l0;
    } dist_row_t;

    // One stored edge
    typedef struct packed {
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   dst;
        logic [WEIGHT_W-1:0] w;
    } edge_t;

endpackage

// File: hw/rtl/sp1h_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sp1h_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/shortest_path_one_halved_edge_top.sv
// Top level: edge loader, distance memory and relaxation sequencer.
//
// Channel   Direction  Handshake          Beat
// cfg       in         cfg_valid/ready    cfg_data = node_count
// edge      in         start & !busy      from_node, to_node, edge_cost, last_edge
// result    out        done strobe        min_cost, reachable
//
// Edges load one per cycle into the edge memory while busy is low.
// The beat marked last_edge starts the search: a clearing pass over node_count
// rows of the distance memory, then relaxation passes over all stored edges
// (each is read; one inside node_count then has its source and destination rows read
// in turn through the one read port, and is relaxed) until a pass changes nothing,
// bounded by 2*node_count+1 passes; then the result row is read.
// Reset clears control state only; memories hold no reset value.
// The result is shown for one cycle with done and cannot be stalled.
`timescale 1ns / 1ps

module shortest_path_one_halved_edge_top
    import sp1h_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [NODE_W-1:0]   from_node,
    input  logic [NODE_W-1:0]   to_node,
    input  logic [WEIGHT_W-1:0] edge_cost,
    input  logic                last_edge,
    output logic                done,
    output logic [COST_W-1:0]   min_cost,
    output logic                reachable
);

    localparam int ROW_W   = $clog2(MAX_NODES);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int CW      = (NCNT_W > CFG_W) ? NCNT_W : CFG_W;
    localparam int EA_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_EREAD = 3'd2;
    localparam logic [2:0] S_SREAD = 3'd3;
    localparam logic [2:0] S_DREAD = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [COST_W-1:0]   min_cost_reg, min_cost_next;
    logic                reachable_reg, reachable_next;
    logic [CFG_W-1:0]    node_count_reg, node_count_next;
    logic [ECNT_W-1:0]   edge_total_reg, edge_total_next;
    logic [ECNT_W-1:0]   k_reg, k_next;
    logic [ROW_W-1:0]    clr_row_reg, clr_row_next;
    logic                changed_reg, changed_next;
    logic [ROW_W-1:0]    dst_row_reg, dst_row_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                src_zero_reg, src_zero_next;
    logic [COST_W:0]     s0_reg, s0_next;
    logic [COST_W:0]     s1a_reg, s1a_next;
    logic [COST_W:0]     s1b_reg, s1b_next;
    logic                v0_reg, v0_next;
    logic                v1b_reg, v1b_next;

    logic                accept;
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       n_last;
    logic [ECNT_W-1:0]   k_inc;
    logic                pass_end;

    logic                edge_we;
    edge_t               edge_wdata;
    edge_t               edge_rdata;

    logic                dist_we;
    logic [ROW_W-1:0]    dist_waddr;
    dist_row_t           dist_wdata;
    logic [ROW_W-1:0]    dist_raddr;
    dist_row_t           dist_rdata;

    logic                src_ok;
    logic                dst_ok;
    logic [COST_W-1:0]   c0;
    logic [COST_W-1:0]   c1a;
    logic [COST_W-1:0]   c1b;
    logic                c1_valid;
    logic [COST_W-1:0]   c1;
    logic                upd0;
    logic                upd1;

    // Accept an edge beat when idle; take configuration only when no edge is offered
    assign accept    = start && !busy_reg;
    assign cfg_ready = !busy_reg && !start;

    // Clamp the node count to the distance memory depth
    assign n_eff  = (CW'(node_count_reg) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                           : CW'(node_count_reg);
    assign n_last = n_eff - CW'(1);

    assign k_inc    = k_reg + ECNT_W'(1);
    assign pass_end = (k_inc == edge_total_reg);

    // Edge memory: one beat per cycle in while idle, addressed by the pass counter out
    assign edge_we        = accept && (edge_total_reg < ECNT_W'(MAX_EDGES));
    assign edge_wdata.src = from_node;
    assign edge_wdata.dst = to_node;
    assign edge_wdata.w   = edge_cost;

    sp1h_ram #(
        .WIDTH ($bits(edge_t)),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_total_reg[EA_W-1:0]),
        .wdata (edge_wdata),
        .raddr (k_reg[EA_W-1:0]),
        .rdata (edge_rdata)
    );

    // Range check of the edge just read
    assign src_ok = CW'(edge_rdata.src) < n_eff;
    assign dst_ok = CW'(edge_rdata.dst) < n_eff;

    // Distance read address follows the sequencer state
    always_comb
    begin
        case (state_reg)
            S_SREAD: dist_raddr = ROW_W'(CW'(edge_rdata.src));
            S_DREAD: dist_raddr = dst_row_reg;
            default: dist_raddr = ROW_W'(n_last);
        endcase
    end

    // Saturate sums so a long walk never wraps
    assign c0  = s0_reg[COST_W]  ? {COST_W{1'b1}} : s0_reg[COST_W-1:0];
    assign c1a = s1a_reg[COST_W] ? {COST_W{1'b1}} : s1a_reg[COST_W-1:0];
    assign c1b = s1b_reg[COST_W] ? {COST_W{1'b1}} : s1b_reg[COST_W-1:0];

    // Pick the better layer-one candidate
    always_comb
    begin
        c1_valid = v0_reg || v1b_reg;
        if (v0_reg && v1b_reg)
        begin
            c1 = (c1b < c1a) ? c1b : c1a;
        end
        else if (v1b_reg)
        begin
            c1 = c1b;
        end
        else
        begin
            c1 = c1a;
        end
    end

    // Compare candidates against the stored destination row
    assign upd0 = v0_reg && (dist_rdata.l0.inf || (c0 < dist_rdata.l0.cost));
    assign upd1 = c1_valid && (dist_rdata.l1.inf || (c1 < dist_rdata.l1.cost));

    // Distance memory write data: clearing rows or relaxed rows
    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = dst_row_reg;
        dist_wdata = dist_rdata;
        if (state_reg == S_CLEAR)
        begin
            dist_we    = 1'b1;
            dist_waddr = clr_row_reg;
            if (clr_row_reg == '0)
            begin
                dist_wdata = '0;
            end
            else
            begin
                dist_wdata.l0.inf  = 1'b1;
                dist_wdata.l0.cost = '0;
                dist_wdata.l1.inf  = 1'b1;
                dist_wdata.l1.cost = '0;
            end
        end
        else if (state_reg == S_UPD)
        begin
            dist_we = upd0 || upd1;
            if (upd0)
            begin
                dist_wdata.l0.inf  = 1'b0;
                dist_wdata.l0.cost = c0;
            end
            if (upd1)
            begin
                dist_wdata.l1.inf  = 1'b0;
                dist_wdata.l1.cost = c1;
            end
        end
    end

    sp1h_ram #(
        .WIDTH ($bits(dist_row_t)),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        done_next       = 1'b0;
        min_cost_next   = min_cost_reg;
        reachable_next  = reachable_reg;
        node_count_next = node_count_reg;
        edge_total_next = edge_total_reg;
        k_next          = k_reg;
        clr_row_next    = clr_row_reg;
        changed_next    = changed_reg;
        dst_row_next    = dst_row_reg;
        w_next          = w_reg;
        src_zero_next   = src_zero_reg;
        s0_next         = s0_reg;
        s1a_next        = s1a_reg;
        s1b_next        = s1b_reg;
        v0_next         = v0_reg;
        v1b_next        = v1b_reg;

        // Take a configuration beat
        if (cfg_valid && cfg_ready)
        begin
            node_count_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (edge_we)
                    begin
                        edge_total_next = edge_total_reg + ECNT_W'(1);
                    end
                    if (last_edge)
                    begin
                        if (n_eff == '0)
                        begin
                            done_next       = 1'b1;
                            min_cost_next   = '0;
                            reachable_next  = 1'b0;
                            edge_total_next = '0;
                        end
                        else
                        begin
                            busy_next    = 1'b1;
                            clr_row_next = '0;
                            state_next   = S_CLEAR;
                        end
                    end
                end
            end
            S_CLEAR:
            begin
                clr_row_next = clr_row_reg + ROW_W'(1);
                if (CW'(clr_row_reg) == n_last)
                begin
                    k_next       = '0;
                    changed_next = 1'b0;
                    state_next   = (edge_total_reg == '0) ? S_RES : S_EREAD;
                end
            end
            S_EREAD:
            begin
                state_next = S_SREAD;
            end
            S_SREAD:
            begin
                dst_row_next  = ROW_W'(CW'(edge_rdata.dst));
                w_next        = edge_rdata.w;
                src_zero_next = (edge_rdata.src == '0);
                if (src_ok && dst_ok)
                begin
                    state_next = S_DREAD;
                end
                else if (pass_end)
                begin
                    k_next       = '0;
                    changed_next = 1'b0;
                    state_next   = changed_reg ? S_EREAD : S_RES;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = S_EREAD;
                end
            end
            S_DREAD:
            begin
                // Form the three candidate sums from the source row
                s0_next    = {1'b0, dist_rdata.l0.cost} + (COST_W + 1)'(w_reg);
                s1a_next   = {1'b0, dist_rdata.l0.cost} + (COST_W + 1)'(w_reg >> 1);
                s1b_next   = {1'b0, dist_rdata.l1.cost} + (COST_W + 1)'(w_reg);
                v0_next    = !dist_rdata.l0.inf;
                v1b_next   = !dist_rdata.l1.inf && !src_zero_reg;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (pass_end)
                begin
                    k_next       = '0;
                    changed_next = 1'b0;
                    state_next   = (changed_reg || upd0 || upd1) ? S_EREAD : S_RES;
                end
                else
                begin
                    k_next       = k_inc;
                    changed_next = changed_reg || upd0 || upd1;
                    state_next   = S_EREAD;
                end
            end
            S_RES:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next       = 1'b1;
                reachable_next  = !dist_rdata.l1.inf;
                min_cost_next   = dist_rdata.l1.inf ? '0 : dist_rdata.l1.cost;
                busy_next       = 1'b0;
                edge_total_next = '0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            node_count_reg <= NODE_COUNT_RST;
            edge_total_reg <= '0;
            k_reg          <= '0;
            clr_row_reg    <= '0;
            changed_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            node_count_reg <= node_count_next;
            edge_total_reg <= edge_total_next;
            k_reg          <= k_next;
            clr_row_reg    <= clr_row_next;
            changed_reg    <= changed_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        min_cost_reg  <= min_cost_next;
        reachable_reg <= reachable_next;
        dst_row_reg   <= dst_row_next;
        w_reg         <= w_next;
        src_zero_reg  <= src_zero_next;
        s0_reg        <= s0_next;
        s1a_reg       <= s1a_next;
        s1b_reg       <= s1b_next;
        v0_reg        <= v0_next;
        v1b_reg       <= v1b_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign min_cost  = min_cost_reg;
    assign reachable = reachable_reg;

    // Busy drops only together with a result
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy_reg) |-> done_reg)
        else $error("busy dropped without a result");

    // Any search state keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> busy_reg)
        else $error("search running while not busy");

    // An unreachable result carries a zero cost
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !reachable_reg) |-> (min_cost_reg == '0))
        else $error("unreachable result with nonzero cost");

    // Edge count never passes the edge memory depth
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ECNT_W'(MAX_EDGES))
        else $error("edge count overflow");

endmodule

// File: test/tb.sv
// Self-checking testbench for the shortest-path-with-one-halved-edge block.
`timescale 1ns / 1ps

module tb
    import sp1h_pkg::*;
();

    localparam int NODE_CAP  = 1024;
    localparam int EDGE_CAP  = 4096;
    localparam longint unsigned COST_NONE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   dst;
        logic [WEIGHT_W-1:0] w;
        logic                last;
    } edge_beat_t;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              reach;
    } path_answer_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    logic                start;
    logic                busy;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] edge_cost;
    logic                last_edge;
    logic                done;
    logic [COST_W-1:0]   min_cost;
    logic                reachable;

    edge_beat_t   pending_edges[$];
    path_answer_t expected_paths[$];

    // predictor state
    logic [CFG_W-1:0]    node_cfg;
    logic [NODE_W-1:0]   graph_src[EDGE_CAP];
    logic [NODE_W-1:0]   graph_dst[EDGE_CAP];
    longint unsigned     graph_w[EDGE_CAP];
    int                  graph_len;
    longint unsigned     best_dist[2*NODE_CAP];
    bit                  settled[2*NODE_CAP];

    int fail_count;
    int cycle_count;
    int burst_left;
    int gap_left;
    int stall_phase;

    shortest_path_one_halved_edge_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .from_node (from_node),
        .to_node   (to_node),
        .edge_cost (edge_cost),
        .last_edge (last_edge),
        .done      (done),
        .min_cost  (min_cost),
        .reachable (reachable)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Relax one state toward a lower cost
    function automatic void relax_state(int s, longint unsigned c);
        if (c < best_dist[s])
            best_dist[s] = c;
    endfunction

    // Two-layer Dijkstra over the stored graph; returns the discounted answer
    function automatic path_answer_t solve_graph(int n);
        path_answer_t ans;
        int best_s;
        longint unsigned best_c;
        int u;
        ans.cost  = '0;
        ans.reach = 1'b0;
        if (n == 0)
            return ans;
        for (int s = 0; s < 2 * n; s++)
        begin
            best_dist[s] = COST_NONE;
            settled[s]   = 1'b0;
        end
        best_dist[0] = 0;
        best_dist[1] = 0;
        // the discounted origin is never expanded
        settled[1] = 1'b1;
        forever
        begin
            best_s = -1;
            best_c = COST_NONE;
            for (int s = 0; s < 2 * n; s++)
                if (!settled[s] && best_dist[s] < best_c)
                begin
                    best_c = best_dist[s];
                    best_s = s;
                end
            if (best_s < 0)
                break;
            settled[best_s] = 1'b1;
            u = best_s / 2;
            for (int k = 0; k < graph_len; k++)
            begin
                if (graph_src[k] >= n || graph_dst[k] >= n || graph_src[k] != u)
                    continue;
                if (best_s % 2 == 1)
                    relax_state(graph_dst[k] * 2 + 1, best_c + graph_w[k]);
                else
                begin
                    relax_state(graph_dst[k] * 2, best_c + graph_w[k]);
                    relax_state(graph_dst[k] * 2 + 1, best_c + (graph_w[k] >> 1));
                end
            end
        end
        if (best_dist[(n - 1) * 2 + 1] != COST_NONE)
        begin
            ans.cost  = best_dist[(n - 1) * 2 + 1][COST_W-1:0];
            ans.reach = 1'b1;
        end
        return ans;
    endfunction

    // Monitor: track config, predict on each accepted beat, check each result
    always @(posedge clk)
    begin
        path_answer_t want;
        int n;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cfg_valid && cfg_ready)
                node_cfg = cfg_data;
            if (done)
            begin
                if (expected_paths.size() == 0)
                begin
                    $error("result with no expectation: min_cost %0d reachable %0b",
                           min_cost, reachable);
                    fail_count++;
                end
                else
                begin
                    want = expected_paths.pop_front();
                    if (min_cost !== want.cost)
                    begin
                        $error("min_cost expected %0d actual %0d", want.cost, min_cost);
                        fail_count++;
                    end
                    if (reachable !== want.reach)
                    begin
                        $error("reachable expected %0b actual %0b", want.reach, reachable);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (graph_len < EDGE_CAP)
                begin
                    graph_src[graph_len] = from_node;
                    graph_dst[graph_len] = to_node;
                    graph_w[graph_len]   = 64'(edge_cost);
                    graph_len++;
                end
                if (last_edge)
                begin
                    n = (node_cfg > NODE_CAP) ? NODE_CAP : node_cfg;
                    expected_paths.insert(expected_paths.size(), solve_graph(n));
                    graph_len = 0;
                end
            end
        end
    end

    // Driver: present queued beats in random bursts
    always @(posedge clk)
    begin
        edge_beat_t b;
        if (rst_n && (!start || !busy))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (pending_edges.size() > 0)
            begin
                b = pending_edges.pop_front();
                start     <= 1'b1;
                from_node <= b.src;
                to_node   <= b.dst;
                edge_cost <= b.w;
                last_edge <= b.last;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Receiver stall pattern: no effect on the block, kept for phase variety
    always @(posedge clk)
        stall_phase <= (stall_phase + 1) % 7;

    // Timeout guard
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_edge(int s, int d, longint unsigned w, bit last);
        edge_beat_t b;
        b.src  = NODE_W'(s);
        b.dst  = NODE_W'(d);
        b.w    = WEIGHT_W'(w);
        b.last = last;
        pending_edges.insert(pending_edges.size(), b);
    endtask

    // Hold until every beat is in, every result is out and the block is no longer busy
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_edges.size() != 0 || expected_paths.size() != 0 || start || busy);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_node_count(int v);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(v);
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random graph over n nodes, mostly in range
    task automatic add_random_graph(int n, int edges);
        int s;
        int d;
        longint unsigned w;
        for (int k = 0; k < edges; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                s = $urandom_range(0, 1023);
                d = $urandom_range(0, 1023);
            end
            else
            begin
                s = $urandom_range(0, n - 1);
                d = $urandom_range(0, n - 1);
            end
            case ($urandom_range(0, 3))
                0: w = $urandom();
                1: w = $urandom_range(0, 3);
                default: w = $urandom_range(0, 1000);
            endcase
            add_edge(s, d, w, k == edges - 1);
        end
    endtask

    // Stimulus
    initial
    begin
        int n;
        fail_count  = 0;
        cycle_count = 0;
        burst_left  = 1;
        gap_left    = 0;
        stall_phase = 0;
        node_cfg    = NODE_COUNT_RST;
        graph_len   = 0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        start     = 1'b0;
        from_node = '0;
        to_node   = '0;
        edge_cost = '0;
        last_edge = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default node count, extremes of weight and node fields
        add_edge(0, 1, 32'hFFFF_FFFF, 1);
        add_edge(0, 1, 0, 1);
        add_edge(1023, 1023, 7, 0);
        add_edge(0, 1023, 5, 0);
        add_edge(1, 0, 9, 1);
        add_edge(0, 1, 10, 0);
        add_edge(0, 1, 3, 0);
        add_edge(0, 1, 100, 1);
        wait_idle();
        // no nodes: no destination
        write_node_count(0);
        add_edge(0, 1, 4, 1);
        wait_idle();
        // one node: destination is the origin
        write_node_count(1);
        add_edge(0, 0, 4, 1);
        wait_idle();
        // widest graph: chain across the full node range
        write_node_count(1024);
        add_edge(0, 512, 1000, 0);
        add_edge(512, 1023, 33, 1);
        add_edge(0, 5, 1, 1);
        wait_idle();
        // count beyond the node cap clamps
        write_node_count(2047);
        add_edge(0, 1023, 21, 1);
        wait_idle();
        write_node_count(3);
        add_edge(0, 1, 8, 0);
        add_edge(1, 2, 8, 0);
        add_edge(0, 2, 30, 1);
        wait_idle();

        // random phases of small graphs
        for (int p = 0; p < 32; p++)
        begin
            n = $urandom_range(2, 12);
            write_node_count(n);
            for (int g = 0; g < 3; g++)
                add_random_graph(n, $urandom_range(1, 12));
            wait_idle();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
